// ===== hdl/rnfp_pkg.sv =====
// Package for the RTP NAL fragment packetiser: payload structs, state codes,
// controller/datapath command and status types, protocol constants.
// No dependencies.
package rnfp_pkg;

    // Limits of the packetiser.
    localparam int unsigned MAX_PAYLOAD_BYTES = 1400;
    localparam int unsigned MAX_NAL_BYTES     = 65535;

    // RTP / FU constants.
    localparam logic [10:0] RTP_HEADER_BYTES = 11'd12;
    localparam logic [7:0]  FU_TYPE_H264     = 8'd28;
    localparam logic [7:0]  FU_TYPE_H265     = 8'd49;
    localparam logic [7:0]  FU_START         = 8'h80;
    localparam logic [7:0]  FU_END           = 8'h40;
    localparam logic [7:0]  H264_NRI_MASK    = 8'hE0;
    localparam logic [7:0]  H264_TYPE_MASK   = 8'h1F;
    localparam logic [7:0]  H265_FZ_MASK     = 8'h81;
    localparam logic [7:0]  H265_TYPE_MASK   = 8'h7E;

    localparam logic [1:0]  PCOUNT_SINGLE = 2'd0;
    localparam logic [1:0]  PCOUNT_H264   = 2'd2;
    localparam logic [1:0]  PCOUNT_H265   = 2'd3;

    localparam logic [15:0] DATA_OFS_H264 = 16'd1;
    localparam logic [15:0] DATA_OFS_H265 = 16'd2;

    localparam logic CODEC_H264 = 1'b0;
    localparam logic CODEC_H265 = 1'b1;

    // Register decode: paddr[2] selects the register.
    localparam int unsigned PADDR_W      = 3;
    localparam logic        REG_CODEC    = 1'b0;
    localparam logic        REG_SSRC     = 1'b1;

    typedef struct packed {
        logic [15:0] nal_length;
        logic [7:0]  header_byte_0;
        logic [7:0]  header_byte_1;
        logic [31:0] rtp_time;
        logic        frame_end;
    } t_in_item;

    typedef struct packed {
        logic        marker;
        logic [15:0] sequence_number;
        logic [31:0] time_out;
        logic [1:0]  prefix_count;
        logic [7:0]  prefix_first;
        logic [7:0]  prefix_second;
        logic [7:0]  prefix_third;
        logic [15:0] payload_offset;
        logic [10:0] payload_length;
        logic [10:0] packet_length;
        logic        last_packet;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FIRST,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load_item;
        logic load_pkt;
    } t_dp_cmd;

    typedef struct packed {
        logic zero_len;
        logic pkt_last;
    } t_dp_status;

endpackage

// ===== hdl/rtp_nal_fragment_packetizer_core.sv =====
// RTP NAL fragment packetiser top level: APB register file, controller and
// datapath. Depends on rnfp_pkg, rnfp_ctrl and rnfp_dp.
//
// Sequence: after the input transfer the controller builds the first packet
// descriptor into the output register in FIRST, and HOLD then presents it.
// Throughput: one descriptor per cycle while i_out_ready is high. Each item is
// taken in IDLE, its first descriptor is built in FIRST, then HOLD presents each
// descriptor in turn, building each further one on a transfer (47 packets max).
// A zero-length NAL passes through IDLE and FIRST and produces nothing.
// Reset (synchronous, active low): controller idle, sequence number 0,
// codec_mode H.264, stream_source_id 0.
module rtp_nal_fragment_packetizer_core
    import rnfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input item channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    // packet descriptor channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    // APB-style register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_codec_mode;
    logic [31:0] r_ssrc;      // readable over the register port only
    logic        cfg_wr;

    t_dp_cmd     cmd;
    t_dp_status  status;

    // ---------------------------------------------------------------------
    // Register file. Writes complete in the access phase; no wait states.
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_codec_mode <= CODEC_H264;
            r_ssrc       <= 32'd0;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CODEC: r_codec_mode <= pwdata[0];
                REG_SSRC:  r_ssrc       <= pwdata;
                default:   r_ssrc       <= r_ssrc;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CODEC: prdata = {31'd0, r_codec_mode};
            REG_SSRC:  prdata = r_ssrc;
            default:   prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Controller: IDLE takes an item, FIRST builds the first descriptor,
    // HOLD presents descriptors and builds the next on each transfer.
    // ---------------------------------------------------------------------
    rnfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    // ---------------------------------------------------------------------
    // Datapath: offset walk, FU prefix build, sequence counter.
    // ---------------------------------------------------------------------
    rnfp_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_item       (i_in_data),
        .i_codec_mode (r_codec_mode),
        .o_status     (status),
        .o_pkt        (o_out_data)
    );

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    // One item at a time: no descriptor pending while taking input.
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a descriptor is pending");

    // Fragments follow back to back.
    a_next_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_packet) |=> o_out_valid)
        else $error("gap between fragments");

    // Sequence number steps by one between fragments of a NAL.
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.last_packet) |=>
        (o_out_data.sequence_number == $past(o_out_data.sequence_number) + 16'd1))
        else $error("sequence number did not advance");

    // Last packet returns the block to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.last_packet) |=> o_in_ready)
        else $error("not idle after last packet");

endmodule

// ===== hdl/rnfp_ctrl.sv =====
// Packetiser controller: sequences item load, packet generation and output
// transfers. Depends on rnfp_pkg.
module rnfp_ctrl
    import rnfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_FIRST;
                end
            end
            ST_FIRST: begin
                // zero-length NAL produces nothing
                if (i_status.zero_len) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (i_out_ready && i_status.pkt_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd.load_item = 1'b0;
        o_cmd.load_pkt  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ST_FIRST: begin
                o_cmd.load_pkt = !i_status.zero_len;
            end
            ST_HOLD: begin
                o_out_valid    = 1'b1;
                o_cmd.load_pkt = i_out_ready && !i_status.pkt_last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/rnfp_dp.sv =====
// Packetiser datapath: item registers, fragment offset, sequence counter and
// the registered packet descriptor. Depends on rnfp_pkg.
module rnfp_dp
    import rnfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  t_in_item   i_item,
    input  logic       i_codec_mode,
    output t_dp_status o_status,
    output t_out_item  o_pkt
);

    localparam logic [15:0] MaxNal = 16'(MAX_NAL_BYTES);
    localparam logic [15:0] MaxPay = 16'(MAX_PAYLOAD_BYTES);

    logic [15:0] r_nal_len;
    logic [7:0]  r_h0;
    logic [7:0]  r_h1;
    logic [31:0] r_time;
    logic        r_fend;
    logic        r_mode;
    logic        r_frag;
    logic        r_first;
    logic [15:0] r_off;
    logic [15:0] r_seq;
    t_out_item   r_out;

    logic [15:0] sat_len;
    logic        sat_frag;
    logic [15:0] rem;
    logic        last;
    logic [10:0] flen;
    logic [7:0]  fuh;
    t_out_item   n_out;

    assign sat_len  = (i_item.nal_length > MaxNal) ? MaxNal : i_item.nal_length;
    assign sat_frag = sat_len > MaxPay;

    // Remaining bytes from the current offset
    assign rem  = r_nal_len - r_off;
    assign last = rem <= MaxPay;
    assign flen = last ? rem[10:0] : MaxPay[10:0];

    always_comb begin
        if (r_mode == CODEC_H265) begin
            fuh = ((r_h0 & H265_TYPE_MASK) >> 1);
        end else begin
            fuh = r_h0 & H264_TYPE_MASK;
        end
        if (r_first) begin
            fuh = fuh | FU_START;
        end
        if (last) begin
            fuh = fuh | FU_END;
        end
    end

    always_comb begin
        n_out.marker          = last & r_fend;
        n_out.sequence_number = r_seq;
        n_out.time_out        = r_time;
        n_out.payload_offset  = r_off;
        n_out.payload_length  = flen;
        n_out.last_packet     = last;
        if (!r_frag) begin
            n_out.prefix_count  = PCOUNT_SINGLE;
            n_out.prefix_first  = 8'd0;
            n_out.prefix_second = 8'd0;
            n_out.prefix_third  = 8'd0;
        end else if (r_mode == CODEC_H265) begin
            n_out.prefix_count  = PCOUNT_H265;
            n_out.prefix_first  = (r_h0 & H265_FZ_MASK) | (FU_TYPE_H265 << 1);
            n_out.prefix_second = r_h1;
            n_out.prefix_third  = fuh;
        end else begin
            n_out.prefix_count  = PCOUNT_H264;
            n_out.prefix_first  = (r_h0 & H264_NRI_MASK) | FU_TYPE_H264;
            n_out.prefix_second = fuh;
            n_out.prefix_third  = 8'd0;
        end
        n_out.packet_length = RTP_HEADER_BYTES + {9'd0, n_out.prefix_count} + flen;
    end

    // Item and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_nal_len <= sat_len;
            r_h0      <= i_item.header_byte_0;
            r_h1      <= i_item.header_byte_1;
            r_time    <= i_item.rtp_time;
            r_fend    <= i_item.frame_end;
            r_mode    <= i_codec_mode;
            r_frag    <= sat_frag;
            r_first   <= 1'b1;
            if (!sat_frag) begin
                r_off <= 16'd0;
            end else if (i_codec_mode == CODEC_H265) begin
                r_off <= DATA_OFS_H265;
            end else begin
                r_off <= DATA_OFS_H264;
            end
        end else if (i_cmd.load_pkt) begin
            r_off   <= r_off + {5'd0, flen};
            r_first <= 1'b0;
        end
        if (i_cmd.load_pkt) begin
            r_out <= n_out;
        end
    end

    // Sequence counter wraps at 16 bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= 16'd0;
        end else if (i_cmd.load_pkt) begin
            r_seq <= r_seq + 16'd1;
        end
    end

    assign o_status.zero_len = r_nal_len == 16'd0;
    assign o_status.pkt_last = r_out.last_packet;
    assign o_pkt             = r_out;

endmodule
